// File: rtl/ssu_pkg.sv
// Package for the sorted unique set union block.
// Holds store sizing, controller states and the command and status structs.
// No dependencies.
package ssu_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic shift_out;
  } cmd_t;

  typedef struct packed {
    logic is_final;
    logic count_one;
  } status_t;

endpackage

// File: rtl/ssu_ctrl.sv
// Controller for the sorted unique set union block.
// Sequences load, insert and drain; depends on ssu_pkg.
module ssu_ctrl
  import ssu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_nxt = status.is_final ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (status.count_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_DRAIN: begin
        cmd.shift_out = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: rtl/ssu_datapath.sv
// Datapath for the sorted unique set union block.
// Sorted insertion register chain, count, overflow flag and result register;
// depends on ssu_pkg.
module ssu_datapath
  import ssu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_final_item,
  output status_t                 status,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_value_res,
  output logic                    out_last,
  output logic                    out_overflow
);

  logic signed [VAL_W-1:0] store_r   [CAPACITY];
  logic signed [VAL_W-1:0] store_nxt [CAPACITY];
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    ovf_r;
  logic                    ovf_nxt;
  logic signed [VAL_W-1:0] val_r;
  logic                    final_r;
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_last_r;
  logic                    out_ovf_r;

  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic                dup;
  logic                full;
  logic                do_ins;

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      lt[k] = (CNT_W'(k) < count_r) && (store_r[k] < val_r);
      eq[k] = (CNT_W'(k) < count_r) && (store_r[k] == val_r);
    end
  end

  assign dup    = |eq;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign do_ins = cmd.insert && !dup && !full;

  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      store_nxt[k] = store_r[k];
      if (do_ins && !lt[k]) begin
        if (k == 0) begin
          store_nxt[k] = val_r;
        end else if (lt[k-1]) begin
          store_nxt[k] = val_r;
        end else begin
          store_nxt[k] = store_r[k-1];
        end
      end else if (cmd.shift_out && (k < CAPACITY - 1)) begin
        store_nxt[k] = store_r[k+1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    priority if (do_ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.insert && !dup && full) begin
      ovf_nxt = 1'b1;
    end else if (cmd.shift_out) begin
      count_nxt = count_r - CNT_W'(1);
      if (status.count_one) begin
        ovf_nxt = 1'b0;
      end
    end else begin
      count_nxt = count_r;
    end
  end

  assign status.is_final  = final_r;
  assign status.count_one = (count_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    for (int k = 0; k < CAPACITY; k++) begin
      store_r[k] <= store_nxt[k];
    end
    if (cmd.load) begin
      val_r   <= in_value;
      final_r <= in_final_item;
    end
    out_value_r <= store_r[0];
    out_last_r  <= status.count_one;
    out_ovf_r   <= ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= cmd.shift_out;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_last      = out_last_r;
  assign out_overflow  = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("store count above capacity");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_out |-> count_r != '0)
    else $error("drain of an empty store");

  a_dup_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && dup |=> $stable(count_r))
    else $error("duplicate changed the count");

  a_ovf_set: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert && !dup && full |=> ovf_r)
    else $error("dropped value did not raise overflow");

endmodule

// File: rtl/sorted_unique_set_union.sv
// Top level of the sorted unique set union block.
// Joins the controller and the datapath; depends on ssu_pkg, ssu_ctrl, ssu_datapath.
//
// Usage:
//   Input: drive in_value and in_final_item with start high; the word is taken
//   at a rising edge where start is high and busy is low.
//   Each word is first captured, then compared against
//   every stored entry in parallel and shifted into place in the register chain.
//   Duplicates leave the store unchanged; a new value arriving at a full
//   store is dropped and raises the overflow flag for the set.
//   A word with in_final_item high is inserted, then the store drains one value
//   per cycle in ascending order, from the head of the chain: out_valid pulses
//   for one cycle per word with out_value_res, out_overflow, and out_last on
//   the final one. The first result appears once the final word has been captured,
//   inserted and read into the result register; busy stays high through the drain,
//   so no new word is taken until the last value has been shifted out of the store.
//   The receiver cannot stall; every result is presented exactly once.
//   Reset (rst_n low, synchronous) empties the store and clears overflow.
module sorted_unique_set_union
  import ssu_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_final_item,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_value_res,
  output logic                    out_last,
  output logic                    out_overflow
);

  cmd_t    cmd;
  status_t status;

  ssu_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ssu_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_value      (in_value),
    .in_final_item (in_final_item),
    .status        (status),
    .out_valid     (out_valid),
    .out_value_res (out_value_res),
    .out_last      (out_last),
    .out_overflow  (out_overflow)
  );

endmodule

// File: bench/sorted_unique_set_union_tb.sv
// Testbench for sorted_unique_set_union: feeds sets of signed words, predicts the sorted
// distinct output of each set with a local store model and checks every result word.
// Depends on ssu_pkg and the sorted_unique_set_union RTL.
module sorted_unique_set_union_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssu_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic                    final_item;
  } word_t;

  typedef struct {
    logic signed [VAL_W-1:0] value_res;
    logic                    last;
    logic                    overflow;
  } union_word_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start = 1'b0;
  logic                    busy;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    in_final_item = 1'b0;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_value_res;
  logic                    out_last;
  logic                    out_overflow;

  word_t                   pending_words[$];
  word_t                   next_word;
  union_word_t             union_expect_q[$];
  union_word_t             got_word;
  logic signed [VAL_W-1:0] set_store[$];
  logic                    set_dropped;
  int                      words_sent;
  int                      errors;
  int                      cycle_count;
  int                      idle_pct;

  sorted_unique_set_union u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_value      (in_value),
    .in_final_item (in_final_item),
    .out_valid     (out_valid),
    .out_value_res (out_value_res),
    .out_last      (out_last),
    .out_overflow  (out_overflow)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= LIMIT_CYCLES);
    $display("FAIL sorted_unique_set_union");
    $finish;
  end

  task automatic merge_word(input logic signed [VAL_W-1:0] v, input logic fin);
    int          pos;
    union_word_t e;
    pos = 0;
    while (pos < set_store.size() && set_store[pos] < v) pos++;
    if (!(pos < set_store.size() && set_store[pos] == v)) begin
      if (set_store.size() >= CAPACITY) set_dropped = 1'b1;
      else set_store.insert(pos, v);
    end
    if (fin) begin
      foreach (set_store[i]) begin
        e.value_res = set_store[i];
        e.last      = (i == set_store.size() - 1);
        e.overflow  = set_dropped;
        union_expect_q.push_back(e);
      end
      set_store.delete();
      set_dropped = 1'b0;
    end
  endtask

  task automatic push_word(input logic signed [VAL_W-1:0] v, input logic fin);
    word_t w;
    w.value      = v;
    w.final_item = fin;
    pending_words.push_back(w);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic signed [VAL_W-1:0] corner[6];
    corner = '{VAL_MIN, VAL_MAX, 0, -1, VAL_MIN + 1, VAL_MAX - 1};
    case ($urandom_range(3))
      0, 1: return int'($urandom_range(16)) - 8;
      2: return $urandom;
      default: return corner[$urandom_range(5)];
    endcase
  endfunction

  // Fill the store to capacity, then add duplicates and optionally one new value.
  task automatic push_full_set(input bit add_new);
    bit                      seen[logic signed [VAL_W-1:0]];
    logic signed [VAL_W-1:0] vals[$];
    logic signed [VAL_W-1:0] v;
    while (vals.size() < CAPACITY) begin
      v = $urandom;
      if (!seen.exists(v)) begin
        seen[v] = 1'b1;
        vals.push_back(v);
        push_word(v, 1'b0);
      end
    end
    push_word(vals[$urandom_range(CAPACITY - 1)], 1'b0);
    if (add_new) begin
      do v = $urandom; while (seen.exists(v));
      push_word(v, 1'b0);
    end
    push_word(vals[$urandom_range(CAPACITY - 1)], 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start         <= 1'b0;
      in_value      <= '0;
      in_final_item <= 1'b0;
    end else begin
      idle_pct = (words_sent >= 40 && words_sent < 90) ? 0 : 34;
      if (start && !busy) begin
        merge_word(in_value, in_final_item);
        words_sent++;
      end
      if (start && busy) begin
        // hold the word until taken
      end else if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_word     = pending_words.pop_front();
        start         <= 1'b1;
        in_value      <= next_word.value;
        in_final_item <= next_word.final_item;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (union_expect_q.size() == 0) begin
        $display("%0t unexpected word: value_res=%0d last=%0b overflow=%0b",
                 $time, out_value_res, out_last, out_overflow);
        errors++;
      end else begin
        got_word = union_expect_q.pop_front();
        if (out_value_res !== got_word.value_res) begin
          $display("%0t value_res mismatch: expected %0d actual %0d",
                   $time, got_word.value_res, out_value_res);
          errors++;
        end
        if (out_last !== got_word.last) begin
          $display("%0t last mismatch: expected %0b actual %0b",
                   $time, got_word.last, out_last);
          errors++;
        end
        if (out_overflow !== got_word.overflow) begin
          $display("%0t overflow mismatch: expected %0b actual %0b",
                   $time, got_word.overflow, out_overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    int n;
    int small_words;
    rst_n       = 1'b0;
    errors      = 0;
    words_sent  = 0;
    set_dropped = 1'b0;
    small_words = 0;

    push_word(0, 1'b0);
    push_word(VAL_MIN, 1'b0);
    push_word(VAL_MAX, 1'b0);
    push_word(-1, 1'b0);
    push_word(1, 1'b0);
    push_word(VAL_MAX, 1'b0);
    push_word(VAL_MIN, 1'b1);
    push_word(32'sh5555_5555, 1'b1);
    push_word(7, 1'b0);
    push_word(7, 1'b0);
    push_word(7, 1'b1);
    push_word(3, 1'b0);
    push_word(-3, 1'b0);
    push_word(32'shaaaa_aaaa, 1'b1);

    push_full_set(1'b1);
    while (small_words < 40) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < n; i++) push_word(pick_value(), i == n - 1);
      small_words += n;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (pending_words.size() != 0 || start || union_expect_q.size() != 0);
    repeat (20) @(negedge clk);

    if (errors == 0) begin
      $display("PASS sorted_unique_set_union");
    end else begin
      $display("FAIL sorted_unique_set_union");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ssu_pkg.sv
rtl/ssu_ctrl.sv
rtl/ssu_datapath.sv
rtl/sorted_unique_set_union.sv
bench/sorted_unique_set_union_tb.sv
